>>> rtl/sdf_pkg.sv
// Shared types and constants for the stream distinct filter.
// No dependencies; used by sdf_table, sdf_search and stream_distinct_filter.
`default_nettype none
package sdf_pkg;

   localparam int MAX_DISTINCT_DEF = 256;
   localparam int VALUE_W          = 32;
   localparam int COUNT_OUT_W      = 9;

   // Table port strobes from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage
`default_nettype wire

>>> rtl/sdf_table.sv
// Distinct-value table: one write port, one read port with registered data.
// Depends on sdf_pkg for the control struct and value width.
`default_nettype none
module sdf_table #(
   parameter int DEPTH = sdf_pkg::MAX_DISTINCT_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                             clock,
   input  wire sdf_pkg::mem_ctl_type       mem_ctl,
   input  wire [AW-1:0]                    rd_addr,
   input  wire [AW-1:0]                    wr_addr,
   input  wire [sdf_pkg::VALUE_W-1:0]      wr_data,
   output logic [sdf_pkg::VALUE_W-1:0]     rd_data
);

   logic [sdf_pkg::VALUE_W-1:0] table_mem [DEPTH];
   logic [sdf_pkg::VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/sdf_search.sv
// Search sequencer: linear scan of the table through one shared comparator,
// append on miss, result beat. Depends on sdf_pkg; drives sdf_table.
`default_nettype none
module sdf_search #(
   parameter int MAX_DISTINCT = sdf_pkg::MAX_DISTINCT_DEF,
   parameter int AW           = $clog2(MAX_DISTINCT),
   parameter int CW           = $clog2(MAX_DISTINCT + 1)
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   input  wire signed [sdf_pkg::VALUE_W-1:0]  req_value,
   input  wire                                req_first_of_job,
   output logic                               busy,
   output sdf_pkg::mem_ctl_type               mem_ctl,
   output logic [AW-1:0]                      rd_addr,
   output logic [AW-1:0]                      wr_addr,
   output logic [sdf_pkg::VALUE_W-1:0]        wr_data,
   input  wire  [sdf_pkg::VALUE_W-1:0]        rd_data,
   output logic                               rsp_valid,
   output logic signed [sdf_pkg::VALUE_W-1:0] rsp_echo_value,
   output logic                               rsp_is_new,
   output logic [sdf_pkg::COUNT_OUT_W-1:0]    rsp_distinct_count,
   output logic                               rsp_overflow
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_DISTINCT);

   logic                                state_ff, state_in;
   logic [CW-1:0]                       idx_ff, idx_in;
   logic                                pend_ff, pend_in;
   logic [CW-1:0]                       count_ff, count_in;
   logic [sdf_pkg::VALUE_W-1:0]         value_ff, value_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [sdf_pkg::VALUE_W-1:0]         echo_ff, echo_in;
   logic                                is_new_ff, is_new_in;
   logic [sdf_pkg::COUNT_OUT_W-1:0]     dcount_ff, dcount_in;
   logic                                over_ff, over_in;
   logic                                hit;
   logic                                miss;

   assign hit  = pend_ff && (rd_data == value_ff);
   assign miss = !pend_ff && (idx_ff == count_ff);

   always_comb begin
      state_in        = state_ff;
      idx_in          = idx_ff;
      pend_in         = pend_ff;
      count_in        = count_ff;
      value_in        = value_ff;
      rsp_valid_in    = 1'b0;
      echo_in         = echo_ff;
      is_new_in       = is_new_ff;
      dcount_in       = dcount_ff;
      over_in         = over_ff;
      mem_ctl.rd_en   = 1'b0;
      mem_ctl.wr_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               idx_in   = '0;
               pend_in  = 1'b0;
               state_in = ST_SEARCH;
               if (req_first_of_job) begin
                  count_in = '0;
               end
            end
         end
         ST_SEARCH: begin
            if (hit) begin
               rsp_valid_in = 1'b1;
               echo_in      = value_ff;
               is_new_in    = 1'b0;
               over_in      = 1'b0;
               dcount_in    = sdf_pkg::COUNT_OUT_W'(count_ff);
               pend_in      = 1'b0;
               state_in     = ST_IDLE;
            end else if (miss) begin
               rsp_valid_in = 1'b1;
               echo_in      = value_ff;
               is_new_in    = 1'b1;
               state_in     = ST_IDLE;
               // append when there is room, else flag and drop
               if (count_ff < COUNT_MAX) begin
                  mem_ctl.wr_en = 1'b1;
                  count_in      = count_ff + CW'(1);
                  dcount_in     = sdf_pkg::COUNT_OUT_W'(count_ff + CW'(1));
                  over_in       = 1'b0;
               end else begin
                  dcount_in = sdf_pkg::COUNT_OUT_W'(count_ff);
                  over_in   = 1'b1;
               end
            end else if (idx_ff < count_ff) begin
               mem_ctl.rd_en = 1'b1;
               idx_in        = idx_ff + CW'(1);
               pend_in       = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      echo_ff   <= echo_in;
      is_new_ff <= is_new_in;
      dcount_ff <= dcount_in;
      over_ff   <= over_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rd_addr            = idx_ff[AW-1:0];
   assign wr_addr            = count_ff[AW-1:0];
   assign wr_data            = value_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_echo_value     = echo_ff;
   assign rsp_is_new         = is_new_ff;
   assign rsp_distinct_count = dcount_ff;
   assign rsp_overflow       = over_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("stored count beyond table depth");

   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_SEARCH) && (state_ff == ST_IDLE))
      else $error("result beat without a finished search");

   a_over_is_new: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_overflow) |-> rsp_is_new)
      else $error("overflow on a value already stored");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (idx_ff <= count_ff))
      else $error("scan index past stored count");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("append did not advance the count");

endmodule
`default_nettype wire

>>> rtl/stream_distinct_filter.sv
// Top level of the stream distinct filter: sequencer plus table memory.
// Depends on sdf_pkg, sdf_table and sdf_search.
//
// Usage: drive req_value and req_first_of_job with start high; the beat is
// taken at an edge where start is high and busy is low. Raise
// req_first_of_job on the first value of a job to empty the stored set.
// Each accepted beat gives exactly one result beat: rsp_valid is high for
// one cycle with rsp_echo_value, rsp_is_new, rsp_distinct_count and
// rsp_overflow. The receiver cannot stall; it must take the beat that cycle.
// Scan: the table is read one entry per cycle through a single
// comparator behind a registered memory read. A hit ends the scan at the
// matching entry; a miss gives its result once every stored value has been
// compared, with no scan at all on an empty table. busy drops in the
// result cycle, so a new value is taken only after the result of the last
// one, and the scan over the table read port sets the pace.
// A new value with the table full reports is_new and overflow and is dropped.
// Reset clears the stored count and the sequencer; table contents need no
// clearing since only entries below the count are ever read.
`default_nettype none
module stream_distinct_filter #(
   parameter int MAX_DISTINCT = sdf_pkg::MAX_DISTINCT_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                start,
   output logic                               busy,
   input  wire signed [sdf_pkg::VALUE_W-1:0]  req_value,
   input  wire                                req_first_of_job,
   output logic                               rsp_valid,
   output logic signed [sdf_pkg::VALUE_W-1:0] rsp_echo_value,
   output logic                               rsp_is_new,
   output logic [sdf_pkg::COUNT_OUT_W-1:0]    rsp_distinct_count,
   output logic                               rsp_overflow
);

   localparam int AW = $clog2(MAX_DISTINCT);
   localparam int CW = $clog2(MAX_DISTINCT + 1);

   sdf_pkg::mem_ctl_type         mem_ctl;
   logic [AW-1:0]                rd_addr;
   logic [AW-1:0]                wr_addr;
   logic [sdf_pkg::VALUE_W-1:0]  wr_data;
   logic [sdf_pkg::VALUE_W-1:0]  rd_data;

   sdf_search #(
      .MAX_DISTINCT (MAX_DISTINCT),
      .AW           (AW),
      .CW           (CW)
   ) u_search (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .req_value          (req_value),
      .req_first_of_job   (req_first_of_job),
      .busy               (busy),
      .mem_ctl            (mem_ctl),
      .rd_addr            (rd_addr),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rd_data            (rd_data),
      .rsp_valid          (rsp_valid),
      .rsp_echo_value     (rsp_echo_value),
      .rsp_is_new         (rsp_is_new),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_overflow       (rsp_overflow)
   );

   sdf_table #(
      .DEPTH (MAX_DISTINCT),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

>>> sim/stream_distinct_filter_tb.sv
// Self-checking testbench for stream_distinct_filter: drives value beats
// and checks each result against a predictor of the distinct-value table.
// Depends on rtl/sdf_pkg.sv and rtl/stream_distinct_filter.sv.
`default_nettype none
module stream_distinct_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W      = sdf_pkg::VALUE_W;
   localparam int COUNT_OUT_W  = sdf_pkg::COUNT_OUT_W;
   localparam int TABLE_DEPTH  = sdf_pkg::MAX_DISTINCT_DEF;
   localparam int RANDOM_BEATS = 1250;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int TAIL_CYCLES  = 2 * TABLE_DEPTH + 10;
   localparam int CALM_FROM    = 300;
   localparam int CALM_TO      = 650;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      first_of_job;
      bit                        drain;
   } value_beat_type;

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      logic                      is_new;
      logic [COUNT_OUT_W-1:0]    count;
      logic                      overflow;
   } dedup_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic req_first_of_job = 1'b0;
   logic rsp_valid;
   logic signed [VALUE_W-1:0] rsp_echo_value;
   logic rsp_is_new;
   logic [COUNT_OUT_W-1:0] rsp_distinct_count;
   logic rsp_overflow;

   value_beat_type    pending_values[$];
   dedup_verdict_type expected_verdicts[$];

   // predictor state
   logic signed [VALUE_W-1:0] seen_values [TABLE_DEPTH];
   int unsigned seen_count = 0;

   int beats_taken    = 0;
   int verdicts_seen  = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;
   int total_beats    = 0;

   stream_distinct_filter #(
      .MAX_DISTINCT(TABLE_DEPTH)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .req_first_of_job  (req_first_of_job),
      .rsp_valid         (rsp_valid),
      .rsp_echo_value    (rsp_echo_value),
      .rsp_is_new        (rsp_is_new),
      .rsp_distinct_count(rsp_distinct_count),
      .rsp_overflow      (rsp_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic dedup_verdict_type predict_verdict(
      input logic signed [VALUE_W-1:0] v,
      input logic fj);
      dedup_verdict_type r;
      bit hit;
      hit = 1'b0;
      if (fj) begin
         seen_count = 0;
      end
      for (int i = 0; i < seen_count; i++) begin
         if (seen_values[i] == v) begin
            hit = 1'b1;
         end
      end
      r.value    = v;
      r.is_new   = !hit;
      r.overflow = 1'b0;
      if (!hit) begin
         if (seen_count < TABLE_DEPTH) begin
            seen_values[seen_count] = v;
            seen_count++;
         end else begin
            r.overflow = 1'b1;
         end
      end
      r.count = seen_count[COUNT_OUT_W-1:0];
      return r;
   endfunction

   function automatic void add_beat(input logic [VALUE_W-1:0] v, input logic fj,
                                    input bit drain);
      value_beat_type b;
      b.value        = v;
      b.first_of_job = fj;
      b.drain        = drain;
      pending_values.insert(pending_values.size(), b);
   endfunction

   // mostly full-range values, with the extremes mixed in
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(19))
         0: v = 32'h8000_0000;
         1: v = 32'h7fff_ffff;
         2: v = 32'h0000_0000;
         3: v = 32'hffff_ffff;
         4: v = 32'h0000_0001;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // driver: hold start until the beat is taken, then load the next one
   always @(posedge clock) begin : drive_beats
      value_beat_type nxt;
      logic go;
      logic lazy;
      int taken_now;
      if (reset) begin
         start            <= 1'b0;
         req_value        <= '0;
         req_first_of_job <= 1'b0;
      end else begin
         go        = start;
         taken_now = beats_taken;
         if (start && !busy) begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     predict_verdict(req_value, req_first_of_job));
            taken_now   = beats_taken + 1;
            beats_taken <= taken_now;
            go          = 1'b0;
         end
         if (!go && pending_values.size() != 0) begin
            lazy = (taken_now < CALM_FROM || taken_now >= CALM_TO) &&
                   ($urandom_range(99) < 10);
            if (pending_values[0].drain && taken_now != verdicts_seen) begin
               lazy = 1'b1;
            end
            if (!lazy) begin
               nxt = pending_values.pop_front();
               req_value        <= nxt.value;
               req_first_of_job <= nxt.first_of_job;
               go = 1'b1;
            end
         end
         start <= go;
      end
   end

   // monitor: every strobed result must match the oldest expectation
   always @(posedge clock) begin : check_results
      dedup_verdict_type want;
      if (!reset && rsp_valid) begin
         verdicts_seen <= verdicts_seen + 1;
         if (expected_verdicts.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected result: value=%0d new=%0b count=%0d ovf=%0b",
                        rsp_echo_value, rsp_is_new, rsp_distinct_count, rsp_overflow);
            end
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_echo_value !== want.value || rsp_is_new !== want.is_new ||
                rsp_distinct_count !== want.count || rsp_overflow !== want.overflow) begin
               if (mismatch_count < 10) begin
                  $display("mismatch: exp value=%0d new=%0b count=%0d ovf=%0b",
                           want.value, want.is_new, want.count, want.overflow);
                  $display("          got value=%0d new=%0b count=%0d ovf=%0b",
                           rsp_echo_value, rsp_is_new, rsp_distinct_count,
                           rsp_overflow);
               end
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] job_pool[$];
      int directed;
      int stored;
      int job_len;
      int fills;
      int jobs;
      bit fj;

      // directed: extremes, hits, and clearing by start of job
      add_beat(32'h8000_0000, 1'b0, 1'b0);
      add_beat(32'h7fff_ffff, 1'b0, 1'b0);
      add_beat(32'h0000_0000, 1'b0, 1'b0);
      add_beat(32'hffff_ffff, 1'b0, 1'b0);
      add_beat(32'h0000_0001, 1'b0, 1'b0);
      add_beat(32'h8000_0000, 1'b0, 1'b0);
      add_beat(32'h5555_5555, 1'b0, 1'b0);
      add_beat(32'haaaa_aaaa, 1'b0, 1'b0);
      add_beat(32'hffff_ffff, 1'b0, 1'b0);
      add_beat(32'h7fff_ffff, 1'b1, 1'b0);
      add_beat(32'h7fff_ffff, 1'b0, 1'b0);
      add_beat(32'h7fff_ffff, 1'b1, 1'b0);
      add_beat(32'h8000_0000, 1'b0, 1'b0);
      add_beat(32'h0000_0000, 1'b1, 1'b0);
      add_beat(32'h0000_0000, 1'b0, 1'b0);
      directed = pending_values.size();

      fills = 0;
      jobs  = 0;
      while (pending_values.size() < directed + RANDOM_BEATS) begin
         if ((fills == 0 && pending_values.size() >= directed + 150) ||
             (fills == 1 && pending_values.size() >= directed + 700)) begin
            // fill the table, then push past it: overflow and hits near the top
            base = $urandom;
            add_beat(base, 1'b1, 1'b1);
            stored = 1;
            while (stored < TABLE_DEPTH) begin
               if ($urandom_range(99) < 15) begin
                  add_beat(base + $urandom_range(stored - 1), 1'b0, 1'b0);
               end else begin
                  add_beat(base + stored, 1'b0, 1'b0);
                  stored++;
               end
            end
            repeat (30) begin
               case ($urandom_range(3))
                  0: add_beat(base + TABLE_DEPTH + $urandom_range(7), 1'b0, 1'b0);
                  1: add_beat(base + TABLE_DEPTH - 1, 1'b0, 1'b0);
                  2: add_beat(base + $urandom_range(TABLE_DEPTH - 1), 1'b0, 1'b0);
                  default: add_beat(pick_value(), 1'b0, 1'b0);
               endcase
            end
            fills++;
         end else begin
            // short job: values drawn from a small pool so repeats are common
            job_pool.delete();
            repeat ($urandom_range(1, 12)) job_pool.insert(job_pool.size(), pick_value());
            job_len = $urandom_range(1, 40);
            for (int k = 0; k < job_len; k++) begin
               fj = (k == 0) ? ($urandom_range(99) < 90) : ($urandom_range(99) < 2);
               if ($urandom_range(99) < 70) begin
                  add_beat(job_pool[$urandom_range(job_pool.size() - 1)], fj,
                           jobs == 0 && k == 0);
               end else begin
                  add_beat(pick_value(), fj, jobs == 0 && k == 0);
               end
            end
         end
         jobs++;
      end
      total_beats = pending_values.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (verdicts_seen < total_beats) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
